>>> hw/rtl/pcfv_pkg.sv
// shared types, constants and the byte-wide crc step for the packet crc field checker
package pcfv_pkg;

    localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  FIELD_BYTES = 8'd4;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FIELD_OFFSET  = 2'd0;
    localparam logic [1:0] REG_FIELD_SIZE    = 2'd1;
    localparam logic [1:0] REG_HEADER_LENGTH = 2'd2;

    // check status codes
    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;
    localparam logic [1:0] STATUS_OUTSIDE  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } pcfv_in_t;

    typedef struct packed {
        logic [31:0] computed_crc;
        logic [31:0] stored_crc;
        logic [1:0]  check_status;
        logic        crc_match;
    } pcfv_out_t;

    typedef struct packed {
        logic [15:0] field_offset;
        logic [7:0]  field_size;
        logic [15:0] header_length;
    } pcfv_cfg_t;

    // one byte through the msb-first crc, no reflection
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {data, 24'd0};
        for (int i = 0; i < 8; i++) begin
            if (crc[31]) begin
                crc = {crc[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[30:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

>>> hw/rtl/pcfv_apb_regs.sv
// apb configuration registers for field offset, field size and header length
module pcfv_apb_regs
    import pcfv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output pcfv_cfg_t   cfg
);

    pcfv_cfg_t   cfg_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_offset  <= 16'd0;
            cfg_reg.field_size    <= FIELD_BYTES;
            cfg_reg.header_length <= 16'd0;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_FIELD_OFFSET:  cfg_reg.field_offset  <= pwdata[15:0];
                REG_FIELD_SIZE:    cfg_reg.field_size    <= pwdata[7:0];
                REG_HEADER_LENGTH: cfg_reg.header_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_index)
            REG_FIELD_OFFSET:  prdata = {16'd0, cfg_reg.field_offset};
            REG_FIELD_SIZE:    prdata = {24'd0, cfg_reg.field_size};
            REG_HEADER_LENGTH: prdata = {16'd0, cfg_reg.header_length};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/pcfv_check.sv
// per-packet state: running crc, byte position, captured field, and the end-of-packet verdict
module pcfv_check
    import pcfv_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  pcfv_cfg_t cfg,
    input  logic      step,
    input  pcfv_in_t  item,
    output pcfv_out_t result
);

    localparam int CMP_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;

    logic [31:0]              crc_reg, crc_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [31:0]              field_reg, field_next;

    logic [CMP_W-1:0] pos_ext, off_ext, hdr_ext, win_end, off_plus4, off_plus3, rel;
    logic             size_ok, in_header, in_window;
    logic [1:0]       byte_idx;
    logic [31:0]      crc_upd;

    // window and header tests on the current byte position
    always_comb begin
        pos_ext   = CMP_W'(pos_reg);
        off_ext   = CMP_W'(cfg.field_offset);
        hdr_ext   = CMP_W'(cfg.header_length);
        size_ok   = (cfg.field_size == FIELD_BYTES);
        win_end   = off_ext + CMP_W'(size_ok ? FIELD_BYTES : cfg.field_size);
        in_header = pos_ext < hdr_ext;
        in_window = (pos_ext >= off_ext) && (pos_ext < win_end);
        rel       = pos_ext - off_ext;
        byte_idx  = rel[1:0];
        off_plus4 = off_ext + CMP_W'(FIELD_BYTES);
        off_plus3 = off_ext + CMP_W'(FIELD_BYTES - 8'd1);
    end

    // crc update: field bytes in the header go in as zero, or are skipped on a bad size
    always_comb begin
        if (in_window && in_header) begin
            crc_upd = size_ok ? crc_byte(crc_reg, 8'd0) : crc_reg;
        end else begin
            crc_upd = crc_byte(crc_reg, item.data_byte);
        end
    end

    // little-endian capture of the field bytes
    always_comb begin
        field_next = field_reg;
        if (size_ok && in_window) begin
            unique case (byte_idx)
                2'd0: field_next[7:0]   = item.data_byte;
                2'd1: field_next[15:8]  = item.data_byte;
                2'd2: field_next[23:16] = item.data_byte;
                2'd3: field_next[31:24] = item.data_byte;
                default: ;
            endcase
        end
    end

    // saturating position count
    assign pos_next = (&pos_reg) ? pos_reg : pos_reg + POSITION_BITS'(1);
    assign crc_next = crc_upd;

    // verdict on the last byte
    always_comb begin
        result.computed_crc = crc_upd;
        result.stored_crc   = 32'd0;
        priority if (!size_ok) begin
            result.check_status = STATUS_BAD_SIZE;
        end else if ((off_plus4 > hdr_ext) || (pos_ext < off_plus3)) begin
            result.check_status = STATUS_OUTSIDE;
        end else begin
            result.stored_crc   = field_next;
            result.check_status = (field_next == crc_upd) ? STATUS_MATCH : STATUS_MISMATCH;
        end
        result.crc_match = (result.check_status == STATUS_MATCH);
    end

    // packet state, cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_INIT;
            pos_reg   <= '0;
            field_reg <= 32'd0;
        end else if (step) begin
            if (item.last_byte) begin
                crc_reg   <= CRC_INIT;
                pos_reg   <= '0;
                field_reg <= 32'd0;
            end else begin
                crc_reg   <= crc_next;
                pos_reg   <= pos_next;
                field_reg <= field_next;
            end
        end
    end

endmodule

>>> hw/rtl/packet_crc_field_verify_core.sv
// top level of the packet crc field checker: input register, check logic, result register
//
// channel   direction  ports                        transaction
// s_        in         s_valid s_ready s_data       one packet byte with its last flag
// m_        out        m_valid m_ready m_data       one verdict per packet, on the last byte
// apb       in/out     psel penable pwrite paddr..  register access
//
// one byte per cycle sustained while no held verdict stalls a last byte; the one-byte crc step
// between the input register and the state/result registers sets that figure
// a verdict is registered in the result register and shown on m_ from there
// reset (aresetn low, synchronous) empties both registers and starts a fresh packet
// a held verdict stalls input only when the next byte waiting is also a last byte
module packet_crc_field_verify_core
    import pcfv_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pcfv_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pcfv_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pcfv_cfg_t cfg;
    pcfv_in_t  in_reg;
    logic      in_valid_reg;
    pcfv_out_t out_reg;
    logic      out_valid_reg;
    pcfv_out_t result;
    logic      advance;

    pcfv_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcfv_check #(
        .POSITION_BITS (POSITION_BITS)
    ) u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .item    (in_reg),
        .result  (result)
    );

    // the held byte moves on unless it needs the result register and that is full
    assign advance = in_valid_reg && (!in_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_reg.last_byte) begin
            out_reg <= result;
        end
    end

    // a last byte that moves on always leaves a verdict behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.last_byte |=> m_valid)
        else $error("last byte left no verdict");

    // match flag agrees with the status code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.crc_match == (m_data.check_status == STATUS_MATCH)))
        else $error("match flag disagrees with status");

    // no stored value is reported when the field is unusable
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.check_status == STATUS_BAD_SIZE ||
                    m_data.check_status == STATUS_OUTSIDE) |-> m_data.stored_crc == 32'd0)
        else $error("stored value reported for unusable field");

    // an empty input register always takes a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input register refused a byte");

endmodule

>>> tb/sv/packet_crc_field_verify_core_test.sv
// self-checking testbench for the packet crc field checker core
module packet_crc_field_verify_core_test;
    import pcfv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POSITION_BITS = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        logic [31:0]              crc;
        logic [POSITION_BITS-1:0] pos;
        logic [31:0]              field;
    } scan_state_t;

    typedef enum logic {ROW_REG, ROW_BYTE} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        pcfv_in_t    item;
        bit          typed;
        pcfv_out_t   want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pcfv_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    pcfv_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pcfv_out_t   verdict_q[$];
    plan_row_t   plan[$];
    logic [7:0]  pkt_bytes[$];
    scan_state_t scan_now;
    pcfv_cfg_t   cfg_now;
    int          fails = 0;
    int          tx_gap_max = 11;
    int          rx_gap_max = 11;
    bit          rx_hold_req = 0;

    packet_crc_field_verify_core #(.POSITION_BITS(POSITION_BITS)) DUT (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // msb-first crc, one data bit at a time
    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[31] ^ d[i];
            c  = {c[30:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic scan_state_t fresh_scan();
        scan_state_t st;
        st.crc   = CRC_INIT;
        st.pos   = '0;
        st.field = '0;
        return st;
    endfunction

    // predicts one byte; returns 1 when the byte closes a packet and res holds the verdict
    function automatic bit scan_byte(inout scan_state_t st, input pcfv_cfg_t c,
                                     input pcfv_in_t it, output pcfv_out_t res);
        int unsigned p;
        int unsigned off;
        int unsigned hl;
        int unsigned wend;
        bit          size4;
        bit          hdr;
        bit          inwin;
        logic [1:0]  status;
        res   = '0;
        p     = st.pos;
        off   = c.field_offset;
        hl    = c.header_length;
        size4 = (c.field_size == FIELD_BYTES);
        wend  = off + (size4 ? 32'd4 : 32'(c.field_size));
        hdr   = p < hl;
        inwin = p >= off && p < wend;
        // field bytes captured little-endian, a saturated position overwrites
        if (size4 && inwin) begin
            st.field[(p - off) * 8 +: 8] = it.data_byte;
        end
        // header field bytes go in as zeros, or are dropped when the size is bad
        if (inwin && hdr) begin
            if (size4) begin
                st.crc = crc_next(st.crc, 8'h00);
            end
        end else begin
            st.crc = crc_next(st.crc, it.data_byte);
        end
        if (st.pos != '1) begin
            st.pos = st.pos + 1'b1;
        end
        if (!it.last_byte) begin
            return 1'b0;
        end
        res.computed_crc = st.crc;
        res.stored_crc   = '0;
        if (!size4) begin
            status = STATUS_BAD_SIZE;
        end else if (off + 4 > hl || p + 1 < off + 4) begin
            status = STATUS_OUTSIDE;
        end else begin
            res.stored_crc = st.field;
            status = (st.field == st.crc) ? STATUS_MATCH : STATUS_MISMATCH;
        end
        res.check_status = status;
        res.crc_match    = (status == STATUS_MATCH);
        st = fresh_scan();
        return 1'b1;
    endfunction

    function automatic pcfv_cfg_t mk_cfg(input int off, input int size, input int hl);
        pcfv_cfg_t c;
        c.field_offset  = off[15:0];
        c.field_size    = size[7:0];
        c.header_length = hl[15:0];
        return c;
    endfunction

    // directed plan entries
    function automatic void plan_reg(input logic [1:0] idx, input logic [31:0] val);
        plan_row_t r;
        r = '{kind: ROW_REG, reg_idx: idx, reg_val: val, item: '0, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_byte(input logic [7:0] d, input logic l);
        plan_row_t r;
        r = '{kind: ROW_BYTE, reg_idx: '0, reg_val: '0, item: '{data_byte: d, last_byte: l},
              typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_verdict(input logic [7:0] d, input logic [31:0] crc,
                                         input logic [1:0] status);
        plan_row_t r;
        r = '{kind: ROW_BYTE, reg_idx: '0, reg_val: '0, item: '{data_byte: d, last_byte: 1'b1},
              typed: 1'b1,
              want: '{computed_crc: crc, stored_crc: 32'd0, check_status: status,
                      crc_match: 1'b0}};
        plan.push_back(r);
    endfunction

    // one packet: when the settings allow, mostly well-formed with a correct, wrong or random field, else noise
    function automatic void make_packet(input pcfv_cfg_t c);
        int unsigned off;
        int unsigned hl;
        int unsigned len;
        int unsigned pick;
        bit          well;
        scan_state_t scratch;
        pcfv_out_t   v;
        pcfv_in_t    it;
        off = c.field_offset;
        hl  = c.header_length;
        pkt_bytes.delete();
        well = c.field_size == FIELD_BYTES && off + 4 <= hl && hl <= 32
               && $urandom_range(0, 3) != 0;
        len = well ? hl + $urandom_range(0, 6) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (well) begin
            // field content does not enter the crc, so a dry run gives the value to plant
            scratch = fresh_scan();
            for (int i = 0; i < len; i++) begin
                it.data_byte = pkt_bytes[i];
                it.last_byte = (i == len - 1);
                void'(scan_byte(scratch, c, it, v));
            end
            pick = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++) begin
                if (pick >= 2) begin
                    pkt_bytes[off + k] = v.computed_crc[k * 8 +: 8];
                end
            end
            if (pick == 2) begin
                pick = $urandom_range(0, 31);
                pkt_bytes[off + pick / 8][pick % 8] = ~pkt_bytes[off + pick / 8][pick % 8];
            end
        end
    endfunction

    // offer one transaction and predict it on acceptance
    task automatic send_byte(input pcfv_in_t it, input int gap, input bit typed,
                             input pcfv_out_t want);
        pcfv_out_t got;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (scan_byte(scan_now, cfg_now, it, got)) begin
            verdict_q.push_back(typed ? want : got);
        end
    endtask

    // stop offering and wait until every verdict is in and the pipe is quiet
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_FIELD_OFFSET:  cfg_now.field_offset  = val[15:0];
            REG_FIELD_SIZE:    cfg_now.field_size    = val[7:0];
            REG_HEADER_LENGTH: cfg_now.header_length = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(input pcfv_cfg_t c);
        drain();
        reg_write(REG_FIELD_OFFSET, 32'(c.field_offset));
        reg_write(REG_FIELD_SIZE, 32'(c.field_size));
        reg_write(REG_HEADER_LENGTH, 32'(c.header_length));
    endtask

    // compare one verdict against the oldest prediction
    task automatic take_verdict(input pcfv_out_t got);
        pcfv_out_t want;
        if (verdict_q.size() == 0) begin
            $error("unexpected verdict: crc %h stored %h status %0d match %0b",
                   got.computed_crc, got.stored_crc, got.check_status, got.crc_match);
            fails++;
        end else begin
            want = verdict_q.pop_front();
            if (got.computed_crc !== want.computed_crc) begin
                $error("computed_crc: expected %h, actual %h", want.computed_crc,
                       got.computed_crc);
                fails++;
            end
            if (got.stored_crc !== want.stored_crc) begin
                $error("stored_crc: expected %h, actual %h", want.stored_crc, got.stored_crc);
                fails++;
            end
            if (got.check_status !== want.check_status) begin
                $error("check_status: expected %0d, actual %0d", want.check_status,
                       got.check_status);
                fails++;
            end
            if (got.crc_match !== want.crc_match) begin
                $error("crc_match: expected %0b, actual %0b", want.crc_match, got.crc_match);
                fails++;
            end
        end
    endtask

    // result side: random back-pressure, with one long hold on request
    initial begin
        int g;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_req) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            g = $urandom_range(0, rx_gap_max);
            if (g > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            take_verdict(m_data);
        end
    end

    // stimulus
    initial begin
        pcfv_cfg_t phase_cfg[$];
        pcfv_in_t  it;
        int        sent;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_now  = mk_cfg(0, 4, 0);
        scan_now = fresh_scan();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings leave the field outside an empty header; crc is the catalog check
        plan_byte(8'h31, 1'b0);
        plan_byte(8'h32, 1'b0);
        plan_byte(8'h33, 1'b0);
        plan_byte(8'h34, 1'b0);
        plan_byte(8'h35, 1'b0);
        plan_byte(8'h36, 1'b0);
        plan_byte(8'h37, 1'b0);
        plan_byte(8'h38, 1'b0);
        plan_verdict(8'h39, 32'h0376_E6E7, STATUS_OUTSIDE);
        // bad size window over the whole packet: nothing enters the crc
        plan_reg(REG_FIELD_SIZE, 32'd8);
        plan_reg(REG_HEADER_LENGTH, 32'd8);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h00, 1'b0);
        plan_verdict(8'hA5, CRC_INIT, STATUS_BAD_SIZE);
        // empty window of size zero
        plan_reg(REG_FIELD_SIZE, 32'd0);
        plan_byte(8'h00, 1'b0);
        plan_byte(8'hFF, 1'b1);
        // packet ends before the last field byte
        plan_reg(REG_FIELD_SIZE, 32'd4);
        plan_reg(REG_FIELD_OFFSET, 32'd2);
        plan_reg(REG_HEADER_LENGTH, 32'd6);
        plan_byte(8'h11, 1'b0);
        plan_byte(8'h22, 1'b0);
        plan_byte(8'h33, 1'b0);
        plan_byte(8'h44, 1'b1);
        // full header plus payload, then a single-byte packet
        plan_byte(8'h01, 1'b0);
        plan_byte(8'h02, 1'b0);
        plan_byte(8'hDE, 1'b0);
        plan_byte(8'hAD, 1'b0);
        plan_byte(8'hBE, 1'b0);
        plan_byte(8'hEF, 1'b0);
        plan_byte(8'h80, 1'b1);
        plan_byte(8'hFF, 1'b1);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                drain();
                reg_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_byte(plan[i].item, $urandom_range(0, tx_gap_max), plan[i].typed,
                          plan[i].want);
            end
        end

        // random phases over several settings, extremes included
        phase_cfg.push_back(mk_cfg(0, 4, 4));
        phase_cfg.push_back(mk_cfg(3, 4, 12));
        phase_cfg.push_back(mk_cfg(10, 4, 16));
        phase_cfg.push_back(mk_cfg(0, 255, 20));
        phase_cfg.push_back(mk_cfg(5, 3, 10));
        phase_cfg.push_back(mk_cfg(65535, 4, 65535));
        phase_cfg.push_back(mk_cfg(8, 4, 4));
        for (int k = 0; k < 2; k++) begin
            sent = $urandom_range(0, 12);
            phase_cfg.push_back(mk_cfg(sent, 4, sent + 4 + $urandom_range(0, 10)));
        end

        foreach (phase_cfg[ph]) begin
            load_cfg(phase_cfg[ph]);
            tx_gap_max = (ph % 3 == 2) ? 0 : 11;
            rx_gap_max = (ph % 4 == 1) ? 0 : 11;
            sent = 0;
            // hold the result side while a run of one-byte packets backs the block up
            if (ph == 2) begin
                rx_hold_req = 1'b1;
                for (int n = 0; n < 12; n++) begin
                    it.data_byte = 8'($urandom_range(0, 255));
                    it.last_byte = 1'b1;
                    send_byte(it, $urandom_range(0, 2), 1'b0, '0);
                    sent++;
                end
            end
            while (sent < 40) begin
                make_packet(phase_cfg[ph]);
                foreach (pkt_bytes[i]) begin
                    it.data_byte = pkt_bytes[i];
                    it.last_byte = (i == pkt_bytes.size() - 1);
                    send_byte(it, $urandom_range(0, tx_gap_max), 1'b0, '0);
                end
                sent += pkt_bytes.size();
            end
        end

        drain();
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
